// ===== rtl/per_device_event_queue_arbiter_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the per-device event queue arbiter
// Implication checks on the rising clock edge, quiet while in reset.
// Empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PER_DEVICE_EVENT_QUEUE_ARBITER_TOP_MACROS_SVH
`define PER_DEVICE_EVENT_QUEUE_ARBITER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PDEQ_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pdeq: implication check failed");
// next-cycle implication
`define PDEQ_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pdeq: next-cycle check failed");
`else
`define PDEQ_ASSERT_IMP(lbl, ck, rst_n, ante, cons)
`define PDEQ_ASSERT_NXT(lbl, ck, rst_n, ante, cons)
`endif

`endif

// ===== rtl/pdeq_pkg.sv =====
// ----------------------------------------------------------------------------
// pdeq_pkg
// Shared types, field widths, command codes and the saturating sum helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pdeq_pkg;

	// default sizing
	localparam int DEVICES_DEF     = 32;
	localparam int QUEUE_DEPTH_DEF = 2;

	// fixed field widths
	localparam int CMD_W  = 2;
	localparam int DEV_FW = 5;
	localparam int WORD_W = 32;
	localparam int SUM_W  = 48;

	// command codes, carried on s_tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_POST  = 2'd0,
		CMD_SERVE = 2'd1,
		CMD_STATS = 2'd2
	} cmd_t;

	// per-device counters held in the statistics memory
	typedef struct packed {
		logic [SUM_W-1:0]  turnaround;
		logic [SUM_W-1:0]  response;
		logic [WORD_W-1:0] served;
		logic [WORD_W-1:0] accepted;
	} dev_stats_t;

	// sum plus delay, held at all ones on overflow
	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
		input logic [WORD_W-1:0] delta);
		logic [SUM_W:0] r;
		r = {1'b0, sum} + (SUM_W + 1)'(delta);
		return r[SUM_W] ? {SUM_W{1'b1}} : r[SUM_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/per_device_event_queue_arbiter_top.sv =====
// ----------------------------------------------------------------------------
// per_device_event_queue_arbiter_top
// Per-device event rings with a fixed-priority server and delay statistics.
// Post and stats: the statistics memory read, then the result register.
// Serve: the statistics memory read, then the ring memory read, then the result
// register. A new word is taken only once the result is loaded, back in idle.
// Reset clears control and the per-device valid and pending bits at once;
// counters read as zero until first written, ring contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "per_device_event_queue_arbiter_top_macros.svh"

module per_device_event_queue_arbiter_top #(
	parameter int DEVICES     = pdeq_pkg::DEVICES_DEF,
	parameter int QUEUE_DEPTH = pdeq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// command word
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// device[4:0], event_id[36:5], event_time[68:37], now[100:69], zero pad
	input  wire logic [103:0] s_tdata,
	// cmd[1:0]
	input  wire logic [1:0]   s_tuser,
	// result word
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// served_device[4:0], served_event_id[36:5], served_event_time[68:37],
	// overflow[69], posted_count[101:70], served_count[133:102],
	// response_sum[181:134], turnaround_sum[229:182], zero pad
	output logic      [231:0] m_tdata,
	// served_valid[0]
	output logic              m_tuser
);

	localparam int WORD_W     = pdeq_pkg::WORD_W;
	localparam int DEV_W      = $clog2(DEVICES);
	localparam int SLOT_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int RING_DEPTH = DEVICES * QUEUE_DEPTH;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int CTR_W      = $bits(pdeq_pkg::dev_stats_t);
	localparam int STAT_W     = CTR_W + 2 * SLOT_W + CNT_W;
	localparam int EV_W       = 2 * WORD_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STAT,
		ST_RING
	} state_t;

	// ring slot advance with wrap
	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
	endfunction

	// flat ring address of a device slot
	function automatic logic [RING_AW-1:0] ring_addr(input logic [DEV_W-1:0] d,
		input logic [SLOT_W-1:0] s);
		return RING_AW'(d) * RING_AW'(QUEUE_DEPTH) + RING_AW'(s);
	endfunction

	state_t              state_q;
	logic                m_tvalid_q;
	logic                m_tuser_q;
	logic [231:0]        m_tdata_q;
	logic [DEVICES-1:0]  nonempty_q;
	logic [DEVICES-1:0]  stat_valid_q;

	// input word fields
	pdeq_pkg::cmd_t      in_cmd;
	logic [4:0]          in_dev;
	logic [WORD_W-1:0]   in_id;
	logic [WORD_W-1:0]   in_time;
	logic [WORD_W-1:0]   in_now;
	logic                accept;
	logic                in_range;

	// first stage
	pdeq_pkg::cmd_t      cmd_s1;
	logic [DEV_W-1:0]    addr_s1;
	logic                ok_s1;
	logic                vld_s1;
	logic [WORD_W-1:0]   id_s1;
	logic [WORD_W-1:0]   time_s1;
	logic [WORD_W-1:0]   now_s1;

	logic                arb_found;
	logic [DEV_W-1:0]    arb_idx;
	logic [DEV_W-1:0]    stat_raddr;

	logic [STAT_W-1:0]   stat_rd;
	logic [STAT_W-1:0]   stat_eff;
	logic [STAT_W-1:0]   stat_wdata;
	logic                stat_we;
	pdeq_pkg::dev_stats_t st_ctr;
	logic [SLOT_W-1:0]   st_rs;
	logic [SLOT_W-1:0]   st_ws;
	logic [CNT_W-1:0]    st_cnt;
	pdeq_pkg::dev_stats_t new_ctr;
	logic [SLOT_W-1:0]   new_rs;
	logic [SLOT_W-1:0]   new_ws;
	logic [CNT_W-1:0]    new_cnt;

	logic [EV_W-1:0]     ring_rd;
	logic                ring_we;
	logic                ring_re;

	logic                full;
	logic                post_go;
	logic                serve_go;
	logic                out_free;
	logic                out_load;

	logic                o_valid;
	logic [4:0]          o_dev;
	logic [WORD_W-1:0]   o_id;
	logic [WORD_W-1:0]   o_time;
	logic                o_ovf;
	pdeq_pkg::dev_stats_t o_ctr;
	logic [231:0]        o_data;

	// unpack the command word
	assign in_cmd   = pdeq_pkg::cmd_t'(s_tuser);
	assign in_dev   = s_tdata[4:0];
	assign in_id    = s_tdata[36:5];
	assign in_time  = s_tdata[68:37];
	assign in_now   = s_tdata[100:69];
	assign in_range = (int'(in_dev) < DEVICES);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// lowest nonempty device
	pdeq_arb #(.N(DEVICES)) u_arb (
		.req   (nonempty_q),
		.found (arb_found),
		.idx   (arb_idx)
	);

	assign stat_raddr = (in_cmd == pdeq_pkg::CMD_SERVE) ? arb_idx : DEV_W'(in_dev);

	// first stage capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= in_cmd;
			addr_s1 <= stat_raddr;
			ok_s1   <= (in_cmd == pdeq_pkg::CMD_SERVE) ? arb_found : in_range;
			vld_s1  <= stat_valid_q[stat_raddr];
			id_s1   <= in_id;
			time_s1 <= in_time;
			now_s1  <= in_now;
		end
	end

	// per-device counters, slots and fill level
	pdeq_ram #(.WIDTH(STAT_W), .DEPTH(DEVICES)) u_stat_ram (
		.clk   (clk),
		.we    (stat_we),
		.waddr (addr_s1),
		.wdata (stat_wdata),
		.re    (accept),
		.raddr (stat_raddr),
		.rdata (stat_rd)
	);

	// entries never written read as zero
	assign stat_eff = vld_s1 ? stat_rd : '0;
	assign {st_cnt, st_ws, st_rs, st_ctr} = stat_eff;

	assign full     = (st_cnt == CNT_W'(QUEUE_DEPTH));
	assign post_go  = (state_q == ST_STAT) && (cmd_s1 == pdeq_pkg::CMD_POST) && ok_s1;
	assign serve_go = (state_q == ST_STAT) && (cmd_s1 == pdeq_pkg::CMD_SERVE) && ok_s1;

	// event rings, id over time
	pdeq_ram #(.WIDTH(EV_W), .DEPTH(RING_DEPTH)) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_addr(addr_s1, st_ws)),
		.wdata ({id_s1, time_s1}),
		.re    (ring_re),
		.raddr (ring_addr(addr_s1, st_rs)),
		.rdata (ring_rd)
	);

	assign ring_we = out_free && post_go;
	assign ring_re = serve_go;
	assign stat_we = out_free && (post_go || (state_q == ST_RING));

	// read-modify-write of the device entry
	always_comb begin
		new_ctr = st_ctr;
		new_rs  = st_rs;
		new_ws  = st_ws;
		new_cnt = st_cnt;
		if (state_q == ST_RING) begin
			new_ctr.turnaround = pdeq_pkg::sat_add(st_ctr.turnaround,
				now_s1 - ring_rd[WORD_W-1:0]);
			new_ctr.served = st_ctr.served + WORD_W'(1);
			new_cnt = st_cnt - CNT_W'(1);
			new_rs  = next_slot(st_rs);
		end else begin
			new_ctr.response = pdeq_pkg::sat_add(st_ctr.response, now_s1 - time_s1);
			new_ctr.accepted = st_ctr.accepted + WORD_W'(1);
			new_ws = next_slot(st_ws);
			if (full) begin
				new_rs = next_slot(st_rs);
			end else begin
				new_cnt = st_cnt + CNT_W'(1);
			end
		end
	end

	assign stat_wdata = {new_cnt, new_ws, new_rs, new_ctr};

	// result word
	assign out_load = out_free &&
		(((state_q == ST_STAT) && !serve_go) || (state_q == ST_RING));

	always_comb begin
		o_valid = 1'b0;
		o_dev   = '0;
		o_id    = '0;
		o_time  = '0;
		o_ovf   = 1'b0;
		o_ctr   = '0;
		case (state_q)
			ST_RING: begin
				o_valid = 1'b1;
				o_dev   = 5'(addr_s1);
				o_id    = ring_rd[EV_W-1:WORD_W];
				o_time  = ring_rd[WORD_W-1:0];
			end
			ST_STAT: begin
				if (post_go) begin
					o_ovf = full;
				end else if ((cmd_s1 == pdeq_pkg::CMD_STATS) && ok_s1) begin
					o_ctr = st_ctr;
				end
			end
			default: begin
				o_valid = 1'b0;
			end
		endcase
	end

	assign o_data = {2'b00, o_ctr.turnaround, o_ctr.response, o_ctr.served,
		o_ctr.accepted, o_ovf, o_time, o_id, o_dev};

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			m_tuser_q  <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				m_tuser_q  <= o_valid;
				m_tdata_q  <= o_data;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_STAT;
					end
				end
				ST_STAT: begin
					if (serve_go) begin
						state_q <= ST_RING;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RING: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-device written and pending flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q   <= '0;
			stat_valid_q <= '0;
		end else if (stat_we) begin
			nonempty_q[addr_s1]   <= (new_cnt != '0);
			stat_valid_q[addr_s1] <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

	// only one word in flight
	`PDEQ_ASSERT_NXT(a_one_in_flight, clk, arst_n, accept, !s_tready)
	// write-back never overlaps a new read of the statistics memory
	`PDEQ_ASSERT_IMP(a_no_wb_on_accept, clk, arst_n, stat_we, !accept)
	// a ring is read only for a device flagged as pending
	`PDEQ_ASSERT_IMP(a_serve_pending, clk, arst_n, (state_q == ST_RING), nonempty_q[addr_s1])
	// pending flag agrees with the stored fill level
	`PDEQ_ASSERT_IMP(a_serve_count, clk, arst_n, (state_q == ST_RING), (st_cnt != '0))

endmodule

`default_nettype wire

// ===== rtl/pdeq_ram.sv =====
// ----------------------------------------------------------------------------
// pdeq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdeq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pdeq_arb.sv =====
// ----------------------------------------------------------------------------
// pdeq_arb
// Fixed-priority pick of the lowest-numbered device with pending events.
// Isolates the lowest set request bit, then encodes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdeq_arb #(
	parameter int N = 32,
	localparam int IW = $clog2(N)
) (
	input  wire logic [N-1:0]  req,
	output logic               found,
	output logic      [IW-1:0] idx
);

	logic [N-1:0] lowest;

	// two's complement trick leaves only the lowest set bit
	assign lowest = req & (~req + N'(1));
	assign found  = |req;

	// one-hot to binary
	always_comb begin
		idx = '0;
		for (int i = 0; i < N; i++) begin
			if (lowest[i]) begin
				idx = idx | IW'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== bench/per_device_event_queue_arbiter_top_tb.sv =====
// ----------------------------------------------------------------------------
// per_device_event_queue_arbiter_top_tb
// Drives post, serve, statistics and unknown command words into the arbiter.
// Each result word is checked field by field against a behavioural copy of
// the per-device rings and counters.
// Directed tests cover the idle state after reset, ring overwrite, priority
// order and wrapping delays. A random traffic run follows, with gaps on both
// sides, then a long output stall and a run of largest delays.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_device_event_queue_arbiter_top_tb;

	localparam int          DEV_COUNT    = pdeq_pkg::DEVICES_DEF;
	localparam int          RING_DEPTH   = pdeq_pkg::QUEUE_DEPTH_DEF;
	localparam int          SUM_BITS     = pdeq_pkg::SUM_W;
	localparam logic [1:0]  CMD_UNKNOWN  = 2'd3;
	localparam int          RANDOM_WORDS = 1500;
	localparam int          WIDE_PAIRS   = 100;
	localparam int          CYCLE_LIMIT  = 3000000;
	localparam int          REPORT_CAP   = 40;

	// one result word, unpacked
	typedef struct {
		logic                served_valid;
		logic [4:0]          served_device;
		logic [31:0]         served_id;
		logic [31:0]         served_tick;
		logic                overflow;
		logic [31:0]         posted;
		logic [31:0]         served;
		logic [SUM_BITS-1:0] response;
		logic [SUM_BITS-1:0] turnaround;
	} outcome_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [231:0] m_tdata;
	logic         m_tuser;

	// behavioural copy of the block state
	logic [31:0]         ring_id   [DEV_COUNT][RING_DEPTH];
	logic [31:0]         ring_tick [DEV_COUNT][RING_DEPTH];
	int                  rd_ptr    [DEV_COUNT];
	int                  wr_ptr    [DEV_COUNT];
	int                  fill      [DEV_COUNT];
	logic [31:0]         posted_tot[DEV_COUNT];
	logic [31:0]         served_tot[DEV_COUNT];
	logic [SUM_BITS-1:0] resp_tot  [DEV_COUNT];
	logic [SUM_BITS-1:0] turn_tot  [DEV_COUNT];

	outcome_t cmd_outcomes[$];
	outcome_t want_r;
	outcome_t got_r;

	int  errors;
	int  words_sent;
	int  words_checked;
	int  overwrites_seen;
	int  serves_hit;
	int  cycle_count;
	int  sink_hold;
	int  sink_stall;
	bit  src_idle_en;
	bit  sink_idle_en;

	per_device_event_queue_arbiter_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// sum plus delay, pinned at all ones once it would pass the top
	function automatic logic [SUM_BITS-1:0] add_capped(input logic [SUM_BITS-1:0] sum,
		input logic [31:0] delta);
		logic [SUM_BITS:0] wide;
		wide = {1'b0, sum} + {17'd0, delta};
		if (wide[SUM_BITS])
			return {SUM_BITS{1'b1}};
		return wide[SUM_BITS-1:0];
	endfunction

	// apply one command to the state copy and give the word it should produce
	function automatic outcome_t run_command(input logic [1:0] op, input logic [4:0] dev,
		input logic [31:0] ev_id, input logic [31:0] ev_tick, input logic [31:0] now_tick);
		outcome_t o;
		int       d;
		o = '{default: '0};
		if (op == pdeq_pkg::CMD_POST && int'(dev) < DEV_COUNT) begin
			d = int'(dev);
			resp_tot[d]   = add_capped(resp_tot[d], now_tick - ev_tick);
			ring_id[d][wr_ptr[d]]   = ev_id;
			ring_tick[d][wr_ptr[d]] = ev_tick;
			posted_tot[d] = posted_tot[d] + 32'd1;
			wr_ptr[d]     = (wr_ptr[d] + 1) % RING_DEPTH;
			if (fill[d] >= RING_DEPTH) begin
				// full ring: oldest entry is lost
				rd_ptr[d]  = (rd_ptr[d] + 1) % RING_DEPTH;
				o.overflow = 1'b1;
			end else begin
				fill[d]++;
			end
		end else if (op == pdeq_pkg::CMD_SERVE) begin
			for (int i = 0; i < DEV_COUNT; i++) begin
				if (fill[i] != 0) begin
					o.served_valid  = 1'b1;
					o.served_device = i[4:0];
					o.served_id     = ring_id[i][rd_ptr[i]];
					o.served_tick   = ring_tick[i][rd_ptr[i]];
					turn_tot[i]   = add_capped(turn_tot[i], now_tick - o.served_tick);
					served_tot[i] = served_tot[i] + 32'd1;
					fill[i]--;
					rd_ptr[i] = (rd_ptr[i] + 1) % RING_DEPTH;
					break;
				end
			end
		end else if (op == pdeq_pkg::CMD_STATS && int'(dev) < DEV_COUNT) begin
			d = int'(dev);
			o.posted     = posted_tot[d];
			o.served     = served_tot[d];
			o.response   = resp_tot[d];
			o.turnaround = turn_tot[d];
		end
		return o;
	endfunction

	// offer one command word and record its outcome once it is taken
	task automatic send_word(input logic [1:0] op, input logic [4:0] dev,
		input logic [31:0] ev_id, input logic [31:0] ev_tick, input logic [31:0] now_tick);
		@(negedge clk);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {3'b000, now_tick, ev_tick, ev_id, dev};
		do @(posedge clk); while (!s_tready);
		cmd_outcomes.push_back(run_command(op, dev, ev_id, ev_tick, now_tick));
		words_sent++;
	endtask

	// stop offering and let every outstanding result arrive
	task automatic drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (cmd_outcomes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [SUM_BITS-1:0] want,
		input logic [SUM_BITS-1:0] got);
		if (want !== got) begin
			if (errors < REPORT_CAP)
				$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
			errors++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_r.served_valid  = m_tuser;
			got_r.served_device = m_tdata[4:0];
			got_r.served_id     = m_tdata[36:5];
			got_r.served_tick   = m_tdata[68:37];
			got_r.overflow      = m_tdata[69];
			got_r.posted        = m_tdata[101:70];
			got_r.served        = m_tdata[133:102];
			got_r.response      = m_tdata[181:134];
			got_r.turnaround    = m_tdata[229:182];
			if (cmd_outcomes.size() == 0) begin
				if (errors < REPORT_CAP)
					$display("%0t: result word with none expected, got %0h / %0h",
						$realtime, m_tuser, m_tdata);
				errors++;
			end else begin
				want_r = cmd_outcomes.pop_front();
				check_field("served_valid", want_r.served_valid, got_r.served_valid);
				check_field("served_device", want_r.served_device, got_r.served_device);
				check_field("served_event_id", want_r.served_id, got_r.served_id);
				check_field("served_event_time", want_r.served_tick, got_r.served_tick);
				check_field("overflow", want_r.overflow, got_r.overflow);
				check_field("posted_count", want_r.posted, got_r.posted);
				check_field("served_count", want_r.served, got_r.served);
				check_field("response_sum", want_r.response, got_r.response);
				check_field("turnaround_sum", want_r.turnaround, got_r.turnaround);
				words_checked++;
				if (want_r.overflow)
					overwrites_seen++;
				if (want_r.served_valid)
					serves_hit++;
			end
		end
	end

	// output side: random stall bursts, plus a long hold when asked
	initial begin
		m_tready   = 1'b0;
		sink_stall = 0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				m_tready = 1'b0;
				sink_hold--;
			end else if (sink_stall > 0) begin
				m_tready = 1'b0;
				sink_stall--;
			end else begin
				m_tready = 1'b1;
				if (sink_idle_en && $urandom_range(0, 4) == 0)
					sink_stall = $urandom_range(1, 8);
			end
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("per_device_event_queue_arbiter_top_tb: errors");
		$finish;
	end

	// empty rings, cleared counters, unknown code
	task automatic test_idle_after_reset();
		send_word(pdeq_pkg::CMD_STATS, 5'd0, '0, '0, '0);
		send_word(pdeq_pkg::CMD_STATS, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(pdeq_pkg::CMD_SERVE, 5'd0, '0, '0, 32'd100);
		send_word(CMD_UNKNOWN, 5'd3, 32'h1234_5678, 32'd5, 32'd9);
		drain_results();
	endtask

	// third post into a two-deep ring drops the oldest entry
	task automatic test_ring_overwrite();
		send_word(pdeq_pkg::CMD_POST, 5'd5, 32'h0000_0000, 32'd10, 32'd15);
		send_word(pdeq_pkg::CMD_POST, 5'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(pdeq_pkg::CMD_POST, 5'd5, 32'hA5A5_5A5A, 32'h0000_0000, 32'h8000_0000);
		send_word(pdeq_pkg::CMD_STATS, 5'd5, '0, '0, '0);
		send_word(pdeq_pkg::CMD_SERVE, 5'd5, '0, '0, 32'h0000_0003);
		send_word(pdeq_pkg::CMD_SERVE, 5'd0, '0, '0, 32'h7FFF_FFFF);
		send_word(pdeq_pkg::CMD_SERVE, 5'd0, '0, '0, 32'd1);
		send_word(pdeq_pkg::CMD_STATS, 5'd5, '0, '0, '0);
		drain_results();
	endtask

	// lowest device number wins regardless of posting order
	task automatic test_fixed_priority();
		send_word(pdeq_pkg::CMD_POST, 5'd31, 32'h3131_3131, 32'd100, 32'd200);
		send_word(pdeq_pkg::CMD_POST, 5'd0, 32'h0000_0001, 32'd300, 32'd300);
		send_word(pdeq_pkg::CMD_POST, 5'd17, 32'h1717_1717, 32'd50, 32'd60);
		send_word(pdeq_pkg::CMD_SERVE, 5'd31, '0, '0, 32'd400);
		send_word(pdeq_pkg::CMD_SERVE, 5'd31, '0, '0, 32'd400);
		send_word(pdeq_pkg::CMD_SERVE, 5'd31, '0, '0, 32'd400);
		drain_results();
	endtask

	// now earlier than the event tick wraps to a large delay
	task automatic test_delay_wrap();
		send_word(pdeq_pkg::CMD_POST, 5'd9, 32'h0909_0909, 32'hFFFF_FFFF, 32'h0000_0000);
		send_word(pdeq_pkg::CMD_POST, 5'd9, 32'h9090_9090, 32'h0000_0001, 32'h0000_0000);
		send_word(pdeq_pkg::CMD_SERVE, 5'd9, '0, '0, 32'h0000_0000);
		send_word(pdeq_pkg::CMD_STATS, 5'd9, '0, '0, '0);
		drain_results();
	endtask

	// mixed traffic, mostly on a few devices so rings fill and compete
	task automatic test_random_traffic();
		logic [1:0]  op;
		logic [4:0]  dev;
		logic [31:0] now_tick;
		logic [31:0] ev_tick;
		int          pick;
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				op = pdeq_pkg::CMD_POST;
			else if (pick < 80)
				op = pdeq_pkg::CMD_SERVE;
			else if (pick < 95)
				op = pdeq_pkg::CMD_STATS;
			else
				op = CMD_UNKNOWN;
			if ($urandom_range(0, 9) < 7)
				dev = 5'($urandom_range(0, 7));
			else
				dev = 5'($urandom_range(0, 31));
			now_tick = $urandom;
			pick = $urandom_range(0, 9);
			if (pick < 6)
				ev_tick = now_tick - $urandom_range(0, 1000);
			else if (pick < 8)
				ev_tick = $urandom;
			else if (pick < 9)
				ev_tick = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
			else
				ev_tick = now_tick + $urandom_range(1, 1000);
			send_word(op, dev, $urandom, ev_tick, now_tick);
		end
		drain_results();
	endtask

	// output held off long enough for the block to stall its input
	task automatic test_input_backpressure();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		@(negedge clk);
		sink_hold = 300;
		for (int n = 0; n < 24; n++) begin
			if (n % 3 == 2)
				send_word(pdeq_pkg::CMD_SERVE, 5'd0, '0, '0, $urandom);
			else
				send_word(pdeq_pkg::CMD_POST, 5'($urandom_range(0, 3)), $urandom, $urandom,
					$urandom);
		end
		drain_results();
	endtask

	// largest possible delays on device 0, back to back, then a stats read
	task automatic test_large_delays();
		logic [31:0] now_tick;
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		for (int n = 0; n < WIDE_PAIRS; n++) begin
			now_tick = $urandom;
			send_word(pdeq_pkg::CMD_POST, 5'd0, $urandom, now_tick + 32'd1, now_tick);
			send_word(pdeq_pkg::CMD_SERVE, 5'd0, '0, '0, now_tick);
		end
		send_word(pdeq_pkg::CMD_STATS, 5'd0, '0, '0, '0);
		drain_results();
	endtask

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = pdeq_pkg::CMD_POST;
		sink_hold    = 0;
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		errors          = 0;
		words_sent      = 0;
		words_checked   = 0;
		overwrites_seen = 0;
		serves_hit      = 0;
		for (int i = 0; i < DEV_COUNT; i++) begin
			rd_ptr[i]     = 0;
			wr_ptr[i]     = 0;
			fill[i]       = 0;
			posted_tot[i] = '0;
			served_tot[i] = '0;
			resp_tot[i]   = '0;
			turn_tot[i]   = '0;
		end
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_idle_after_reset();
		test_ring_overwrite();
		test_fixed_priority();
		test_delay_wrap();
		test_random_traffic();
		test_input_backpressure();
		test_large_delays();

		if (cmd_outcomes.size() != 0) begin
			$display("%0t: %0d result words never arrived", $realtime, cmd_outcomes.size());
			errors++;
		end
		$display("%0d command words sent, %0d result words checked", words_sent, words_checked);
		$display("%0d ring overwrites, %0d serves found an event", overwrites_seen, serves_hit);
		if (errors == 0)
			$display("per_device_event_queue_arbiter_top_tb: clean");
		else
			$display("per_device_event_queue_arbiter_top_tb: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pdeq_pkg.sv
rtl/pdeq_ram.sv
rtl/pdeq_arb.sv
rtl/per_device_event_queue_arbiter_top.sv
bench/per_device_event_queue_arbiter_top_tb.sv
